// File: rtl/vn_pkg.sv
`timescale 1ns / 1ps
package vn_pkg;

  localparam int CompW = 16;
  localparam int FracB = 14;
  localparam int OutW  = FracB + 2;
  // Quotient bits found by the cells, one cell per bit.
  localparam int QW    = FracB + 1;
  localparam int NCell = QW;
  localparam int BitW  = (QW > 1) ? $clog2(QW) : 1;
  localparam int SqW   = 2 * CompW + 2;
  localparam int RhsW  = 2 * CompW + 2 * FracB;
  localparam int AccW  = 2 * CompW + 2 * FracB + 4;

  typedef struct packed {
    logic signed [CompW-1:0] comp_x;
    logic signed [CompW-1:0] comp_y;
    logic signed [CompW-1:0] comp_z;
  } vn_in_t;

  typedef struct packed {
    logic signed [OutW-1:0] unit_x;
    logic signed [OutW-1:0] unit_y;
    logic signed [OutW-1:0] unit_z;
    logic                   zero_vector;
  } vn_out_t;

  // One component on its way through the cells.
  typedef struct packed {
    logic            neg;
    logic [RhsW-1:0] rhs;    // mag^2 << 2F
    logic [AccW-1:0] acc_a;  // q^2 * S
    logic [AccW-1:0] acc_b;  // q * S
    logic [QW-1:0]   q;
  } vn_lane_t;

  typedef struct packed {
    logic [SqW-1:0]    sq;
    logic              zero;
    vn_lane_t [2:0]    lane;
  } vn_stage_t;

endpackage

// File: rtl/vn_prep.sv
`timescale 1ns / 1ps
module vn_prep (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  vn_pkg::vn_in_t    data_i,
  output logic              valid_o,
  output vn_pkg::vn_stage_t stage_o
);
  import vn_pkg::*;

  logic [2:0][CompW-1:0] raw;
  logic [2:0][CompW-1:0] mag;
  logic [2:0]            neg;
  logic [2:0][2*CompW-1:0] mag_sq;
  logic [SqW-1:0]        sq;
  logic                  valid_q, valid_d;
  vn_stage_t             stage_q, stage_d;

  assign raw[0] = data_i.comp_x;
  assign raw[1] = data_i.comp_y;
  assign raw[2] = data_i.comp_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg[i]    = raw[i][CompW-1];
      mag[i]    = neg[i] ? (~raw[i] + CompW'(1)) : raw[i];
      mag_sq[i] = mag[i] * mag[i];
    end
    sq = SqW'(mag_sq[0]) + SqW'(mag_sq[1]) + SqW'(mag_sq[2]);
    stage_d.sq   = sq;
    stage_d.zero = (sq == '0);
    for (int i = 0; i < 3; i++) begin
      stage_d.lane[i].neg   = neg[i];
      stage_d.lane[i].rhs   = RhsW'(mag_sq[i]) << (2 * FracB);
      stage_d.lane[i].acc_a = '0;
      stage_d.lane[i].acc_b = '0;
      stage_d.lane[i].q     = '0;
    end
    valid_d = valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;
endmodule

// File: rtl/vn_cell.sv
`timescale 1ns / 1ps
module vn_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [vn_pkg::BitW-1:0] bit_idx_i,
  input  logic              valid_i,
  input  vn_pkg::vn_stage_t stage_i,
  output logic              valid_o,
  output vn_pkg::vn_stage_t stage_o
);
  import vn_pkg::*;

  logic      valid_q;
  vn_stage_t stage_q, stage_d;
  logic [AccW-1:0] cand [3];
  logic [AccW-1:0] sq_ext;

  // Trying bit b: (q + 2^b)^2 * S = q^2*S + 2^(b+1)*q*S + 2^(2b)*S.
  always_comb begin
    stage_d = stage_i;
    sq_ext  = AccW'(stage_i.sq);
    for (int i = 0; i < 3; i++) begin
      cand[i] = stage_i.lane[i].acc_a
              + (stage_i.lane[i].acc_b << (AccW'(bit_idx_i) + AccW'(1)))
              + (sq_ext << (AccW'(bit_idx_i) << 1));
      if (cand[i] <= AccW'(stage_i.lane[i].rhs)) begin
        stage_d.lane[i].acc_a = cand[i];
        stage_d.lane[i].acc_b = stage_i.lane[i].acc_b + (sq_ext << bit_idx_i);
        stage_d.lane[i].q     = stage_i.lane[i].q | (QW'(1) << bit_idx_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;
endmodule

// File: rtl/vector3_normalize.sv
`timescale 1ns / 1ps
// Normalizes one 3D vector of signed Q8.8 components to a unit vector in signed
// Q1.14 (16384 is 1.0), each component truncated toward zero against the exact
// root of the squared length. A zero vector gives zeros and sets zero_vector.
// One request is taken every cycle unless the output stalls; each result passes
// through one squaring stage, a row of 15 cells that each settle one quotient
// bit for all three components, and the output register. A stall on the
// output freezes the whole row and stalls the input in the same cycle.
module vector3_normalize (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  vn_pkg::vn_in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output vn_pkg::vn_out_t out_data_o
);
  import vn_pkg::*;

  logic      en;
  logic      valid  [NCell+1];
  vn_stage_t stage  [NCell+1];
  logic      out_valid_q;
  vn_out_t   out_q, out_d;
  vn_stage_t last;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  vn_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (valid[0]),
    .stage_o (stage[0])
  );

  for (genvar k = 0; k < NCell; k++) begin : g_cell
    vn_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .bit_idx_i (BitW'(FracB - k)),
      .valid_i   (valid[k]),
      .stage_i   (stage[k]),
      .valid_o   (valid[k+1]),
      .stage_o   (stage[k+1])
    );
  end

  assign last = stage[NCell];

  always_comb begin
    logic [2:0][OutW-1:0] u;
    for (int i = 0; i < 3; i++) begin
      u[i] = last.lane[i].neg ? (~OutW'(last.lane[i].q) + OutW'(1))
                              : OutW'(last.lane[i].q);
      if (last.zero) begin
        u[i] = '0;
      end
    end
    out_d.unit_x      = u[0];
    out_d.unit_y      = u[1];
    out_d.unit_z      = u[2];
    out_d.zero_vector = last.zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid[NCell];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule
